@@ sv/ppc_pkg.sv @@
// Shared constants and register codes for the positional PID controller.
// No dependencies; used by positional_pid_controller_top.
package ppc_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int LIMIT_WIDTH = DATA_WIDTH - 1;
   localparam int DIFF_WIDTH  = DATA_WIDTH + 1;
   localparam int PROD_WIDTH  = DATA_WIDTH + DIFF_WIDTH;
   localparam int SUM_WIDTH   = DATA_WIDTH + 2;
   localparam int CSR_IDX_WIDTH = 3;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_DEAD_BAND      = 3'd3,
      CSR_INTEGRAL_LIMIT = 3'd4,
      CSR_OUTPUT_LIMIT   = 3'd5
   } csr_index_type;

endpackage

@@ sv/positional_pid_controller_top.sv @@
// Positional PID controller with dead band, integral clamp and output clamp.
// Depends on ppc_pkg for widths and register codes.
//
// Usage:
//   req_* carries one signed Q16.16 error sample per request (req_tdata).
//   rsp_* returns one result per request: drive_out, p_term, i_term, d_term,
//   each 32-bit signed Q16.16, packed from the lowest bit up in rsp_tdata.
//   csr_* writes the gains, dead band and limits, one per cycle with csr_wr_en high;
//   the user must make writes only while the controller is idle (not enforced).
// Timing:
//   four register stages: input, integral/derivative update, multiply,
//   saturate/sum/clamp. rsp_tvalid rises once a request has passed the update,
//   multiply and output stages. One request per cycle is sustained while rsp_tready
//   is high, as the integral and previous error take one add-and-clamp step each.
// Reset: synchronous, active high; clears the integral, the previous error,
//   all configuration registers and every stage valid bit.
// Stall: each stage holds while the stage behind it is full and blocked, so
//   requests keep flowing into empty stages while a result waits on rsp_tready.
module positional_pid_controller_top #(
   parameter int FRAC_BITS = ppc_pkg::FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // request: error_in [31:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ppc_pkg::DATA_WIDTH-1:0]      req_tdata,
   // response: drive_out [31:0], p_term [63:32], i_term [95:64], d_term [127:96]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [4*ppc_pkg::DATA_WIDTH-1:0]    rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [ppc_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [ppc_pkg::DATA_WIDTH-1:0]      csr_wdata
);

   localparam int DW = ppc_pkg::DATA_WIDTH;
   localparam int LW = ppc_pkg::LIMIT_WIDTH;
   localparam int FW = ppc_pkg::DIFF_WIDTH;
   localparam int PW = ppc_pkg::PROD_WIDTH;
   localparam int SW = ppc_pkg::SUM_WIDTH;

   localparam logic signed [PW-1:0] TERM_MAX = {{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}};
   localparam logic signed [PW-1:0] TERM_MIN = {{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}};

   // configuration
   logic signed [DW-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [LW-1:0]        dead_band_ff, integral_limit_ff, output_limit_ff;

   // controller state
   logic signed [DW-1:0] integral_acc_ff, integral_acc_in;
   logic signed [DW-1:0] prev_error_ff;

   // pipeline
   logic                 s0_valid_ff, s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic signed [DW-1:0] s0_error_ff;
   logic signed [DW-1:0] s1_error_ff, s1_error_in;
   logic signed [DW-1:0] s1_integral_ff;
   logic signed [FW-1:0] s1_diff_ff, s1_diff_in;
   logic signed [PW-1:0] s2_prod_p_ff, s2_prod_i_ff, s2_prod_d_ff;
   logic signed [PW-1:0] s2_prod_p_in, s2_prod_i_in, s2_prod_d_in;
   logic signed [DW-1:0] out_drive_ff, out_p_ff, out_i_ff, out_d_ff;
   logic signed [DW-1:0] out_drive_in, out_p_in, out_i_in, out_d_in;

   logic out_load, s2_load, s1_load, s0_load;

   assign out_load = !out_valid_ff || rsp_tready;
   assign s2_load  = !s2_valid_ff || out_load;
   assign s1_load  = !s1_valid_ff || s2_load;
   assign s0_load  = !s0_valid_ff || s1_load;

   assign req_tready = s0_load;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_d_ff, out_i_ff, out_p_ff, out_drive_ff};

   // floor shift to the fixed-point scale, then saturate to the data width
   function automatic logic signed [DW-1:0] sat_term(input logic signed [PW-1:0] prod);
      logic signed [PW-1:0] sh;
      sh = prod >>> FRAC_BITS;
      if (sh > TERM_MAX) begin
         sat_term = TERM_MAX[DW-1:0];
      end else if (sh < TERM_MIN) begin
         sat_term = TERM_MIN[DW-1:0];
      end else begin
         sat_term = sh[DW-1:0];
      end
   endfunction

   // stage 1: dead band, integral update, error difference
   logic [DW-1:0]        err_mag;
   logic signed [DW-1:0] err_dz;
   logic signed [FW-1:0] int_sum, int_lim, int_lim_neg;

   always_comb begin
      err_mag = s0_error_ff[DW-1] ? (~s0_error_ff + 1'b1) : s0_error_ff;
      err_dz  = (err_mag < {1'b0, dead_band_ff}) ? '0 : s0_error_ff;
      int_sum = {integral_acc_ff[DW-1], integral_acc_ff} + {err_dz[DW-1], err_dz};
      int_lim = {2'b00, integral_limit_ff};
      int_lim_neg = -int_lim;
      if (int_sum > int_lim) begin
         integral_acc_in = int_lim[DW-1:0];
      end else if (int_sum < int_lim_neg) begin
         integral_acc_in = int_lim_neg[DW-1:0];
      end else begin
         integral_acc_in = int_sum[DW-1:0];
      end
      s1_error_in = err_dz;
      s1_diff_in  = {err_dz[DW-1], err_dz} - {prev_error_ff[DW-1], prev_error_ff};
   end

   // stage 2: full-width products
   always_comb begin
      s2_prod_p_in = PW'(gain_p_ff) * PW'(s1_error_ff);
      s2_prod_i_in = PW'(gain_i_ff) * PW'(s1_integral_ff);
      s2_prod_d_in = PW'(gain_d_ff) * PW'(s1_diff_ff);
   end

   // stage 3: saturate terms, sum, output clamp
   logic signed [SW-1:0] term_sum, out_lim, out_lim_neg;

   always_comb begin
      out_p_in = sat_term(s2_prod_p_ff);
      out_i_in = sat_term(s2_prod_i_ff);
      out_d_in = sat_term(s2_prod_d_ff);
      term_sum = SW'(out_p_in) + SW'(out_i_in) + SW'(out_d_in);
      out_lim  = {{(SW-LW){1'b0}}, output_limit_ff};
      out_lim_neg = -out_lim;
      if (term_sum > out_lim) begin
         out_drive_in = out_lim[DW-1:0];
      end else if (term_sum < out_lim_neg) begin
         out_drive_in = out_lim_neg[DW-1:0];
      end else begin
         out_drive_in = term_sum[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         dead_band_ff      <= '0;
         integral_limit_ff <= '0;
         output_limit_ff   <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            ppc_pkg::CSR_GAIN_P:         gain_p_ff         <= csr_wdata;
            ppc_pkg::CSR_GAIN_I:         gain_i_ff         <= csr_wdata;
            ppc_pkg::CSR_GAIN_D:         gain_d_ff         <= csr_wdata;
            ppc_pkg::CSR_DEAD_BAND:      dead_band_ff      <= csr_wdata[LW-1:0];
            ppc_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_wdata[LW-1:0];
            ppc_pkg::CSR_OUTPUT_LIMIT:   output_limit_ff   <= csr_wdata[LW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff     <= 1'b0;
         s1_valid_ff     <= 1'b0;
         s2_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         integral_acc_ff <= '0;
         prev_error_ff   <= '0;
      end else begin
         if (s0_load) begin
            s0_valid_ff <= req_tvalid;
         end
         if (s1_load) begin
            s1_valid_ff <= s0_valid_ff;
            // state moves only when a request leaves the input stage
            if (s0_valid_ff) begin
               integral_acc_ff <= integral_acc_in;
               prev_error_ff   <= err_dz;
            end
         end
         if (s2_load) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_load) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_error_ff <= req_tdata;
      end
      if (s1_load) begin
         s1_error_ff    <= s1_error_in;
         s1_integral_ff <= integral_acc_in;
         s1_diff_ff     <= s1_diff_in;
      end
      if (s2_load) begin
         s2_prod_p_ff <= s2_prod_p_in;
         s2_prod_i_ff <= s2_prod_i_in;
         s2_prod_d_ff <= s2_prod_d_in;
      end
      if (out_load) begin
         out_drive_ff <= out_drive_in;
         out_p_ff     <= out_p_in;
         out_i_ff     <= out_i_in;
         out_d_ff     <= out_d_in;
      end
   end

   // integral changes only when a request passes the update stage
   assert property (@(posedge clock) disable iff (reset)
      !(s1_load && s0_valid_ff) |=> $stable(integral_acc_ff))
      else $error("integral changed without a request");

   // a blocked multiply stage keeps its integral and derivative products
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s2_load |=> s2_valid_ff && $stable(s2_prod_i_ff)
         && $stable(s2_prod_d_ff))
      else $error("multiply stage lost data under stall");

   // the delivered drive never leaves the output clamp
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (SW'(out_drive_ff) <= out_lim) && (SW'(out_drive_ff) >= out_lim_neg))
      else $error("drive outside output limit");

endmodule
